// ----- hdl/qtd_pkg.sv -----
// ============================================================================
// Quadtree image decoder package
// Shared types and fixed constants of the quadtree image decoder.
// ============================================================================
`default_nettype none

package qtd_pkg;

  // One rectangular region: inclusive top-left corner, exclusive bottom-right.
  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } region_t;

  // Shift commands that the decoder hands to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // Code characters.
  localparam logic [7:0] SYM_SPLIT = 8'h32;
  localparam logic [7:0] SYM_ZERO  = 8'h30;
  localparam logic [7:0] SYM_SPACE = 8'h20;
  localparam logic [7:0] SYM_TAB   = 8'h09;
  localparam logic [7:0] SYM_CR    = 8'h0D;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/qtd_if.sv -----
// ============================================================================
// Quadtree image decoder channels
// Valid/ready channels for code symbols in and fill rectangles out.
// ============================================================================
`default_nettype none

interface qtd_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface qtd_rect_if;
  logic        valid;
  logic        ready;
  logic [15:0] rect_x0;
  logic [15:0] rect_y0;
  logic [15:0] rect_x1;
  logic [15:0] rect_y1;
  logic [15:0] fill_value;
  logic        tree_done;
  logic        overflow_error;

  modport source (
    output valid, output rect_x0, output rect_y0, output rect_x1, output rect_y1,
    output fill_value, output tree_done, output overflow_error, input ready
  );
  modport sink (
    input valid, input rect_x0, input rect_y0, input rect_x1, input rect_y1,
    input fill_value, input tree_done, input overflow_error, output ready
  );
endinterface

`default_nettype wire

// ----- hdl/quadtree_image_decoder.sv -----
// ============================================================================
// Quadtree image decoder
// Turns a preorder quadtree code into a stream of fill rectangles.
// ============================================================================
// The decoder takes one code character per clock cycle and gives at most one
// fill rectangle for it. A '2' splits the current region at its midpoints:
// the NW child becomes current and NE, SE, SW are pushed onto a stack built
// as a chain of 3*MAX_LEVELS identical cells, so a split shifts the chain down
// by three and a leaf shifts it up by one. Whitespace
// (tab through carriage return, and space) is taken and ignored. Any other
// character is a leaf and produces a rectangle whose fill value is the
// character minus '0'; a leaf taken with the stack empty carries tree_done, and
// the next character starts a new tree from the root region (0, 0,
// image_width, image_height). A split that would overfill the stack produces
// one result with overflow_error set and all other fields zero, and drops the
// tree. Rectangles with zero width or height are sent as they are. The result
// sits in an output register, and a new symbol is taken in every cycle in
// which that register is empty or is being transferred, so the rate is one
// symbol per cycle while the output side keeps up. The width and height
// registers may be written only while the decoder is idle; they are sampled
// when a tree starts.
// ============================================================================
`default_nettype none

module quadtree_image_decoder #(
  parameter int MAX_LEVELS = 17
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qtd_sym_if.sink          sym_chan,
  qtd_rect_if.source       rect_chan,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DEPTH = 3 * MAX_LEVELS;
  localparam int CW    = $clog2(DEPTH + 1);

  // Configuration registers.
  logic [15:0] image_width;
  logic [15:0] image_height;

  // Decoder state.
  qtd_pkg::region_t cur;
  logic [CW-1:0]    count;
  logic             active;

  // Output register.
  logic             out_valid;
  qtd_pkg::region_t out_rect;
  logic [15:0]      out_fill;
  logic             out_done;
  logic             out_ovf;

  // Stack chain.
  qtd_pkg::region_t   cell_q [DEPTH];
  qtd_pkg::region_t   new_child [3];
  qtd_pkg::cell_ctrl_t ctrl;

  logic             accept;
  logic             is_space;
  logic             is_split;
  qtd_pkg::region_t root;
  qtd_pkg::region_t eff_cur;
  logic [CW-1:0]    eff_count;
  logic [CW:0]      count_plus3;
  logic             overflow;
  logic             have_pending;
  logic [16:0]      sum_x;
  logic [16:0]      sum_y;
  logic [15:0]      mid_x;
  logic [15:0]      mid_y;
  qtd_pkg::region_t nw_child;

  // A new symbol is taken whenever the output register is free this cycle.
  assign sym_chan.ready = !out_valid || rect_chan.ready;
  assign accept         = sym_chan.valid && sym_chan.ready;

  always_comb begin
    is_space = (sym_chan.symbol == qtd_pkg::SYM_SPACE) ||
               ((sym_chan.symbol >= qtd_pkg::SYM_TAB) &&
                (sym_chan.symbol <= qtd_pkg::SYM_CR));
    is_split = (sym_chan.symbol == qtd_pkg::SYM_SPLIT);
  end

  // When no tree is active the root region and an empty stack stand in for
  // the stored state; this is how a new tree starts.
  always_comb begin
    root.x0      = 16'd0;
    root.y0      = 16'd0;
    root.x1      = image_width;
    root.y1      = image_height;
    eff_cur      = active ? cur : root;
    eff_count    = active ? count : '0;
    count_plus3  = {1'b0, eff_count} + (CW + 1)'(3);
    overflow     = count_plus3 > (CW + 1)'(DEPTH);
    have_pending = (eff_count != '0);
  end

  // Midpoints use one extra bit so the sum never wraps.
  always_comb begin
    sum_x = {1'b0, eff_cur.x0} + {1'b0, eff_cur.x1};
    sum_y = {1'b0, eff_cur.y0} + {1'b0, eff_cur.y1};
    mid_x = sum_x[16:1];
    mid_y = sum_y[16:1];

    nw_child = '{x0: eff_cur.x0, y0: eff_cur.y0, x1: mid_x, y1: mid_y};
    // Top of the stack is cell 0, so NE pops first, then SE, then SW.
    new_child[0] = '{x0: mid_x, y0: eff_cur.y0, x1: eff_cur.x1, y1: mid_y};
    new_child[1] = '{x0: mid_x, y0: mid_y, x1: eff_cur.x1, y1: eff_cur.y1};
    new_child[2] = '{x0: eff_cur.x0, y0: mid_y, x1: mid_x, y1: eff_cur.y1};
  end

  always_comb begin
    ctrl.push = accept && !is_space && is_split && !overflow;
    ctrl.pop  = accept && !is_space && !is_split && have_pending;
  end

  // The stack: on a push every cell takes the value three places above it,
  // and the top three cells take the new children; on a pop every cell takes
  // the value of its lower neighbor, and the last cell keeps its own.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qtd_pkg::region_t push_src;
    qtd_pkg::region_t pop_src;

    if (i < 3) begin : g_top
      assign push_src = new_child[i];
    end else begin : g_deep
      assign push_src = cell_q[i-3];
    end

    if (i < DEPTH - 1) begin : g_link
      assign pop_src = cell_q[i+1];
    end else begin : g_end
      assign pop_src = cell_q[i];
    end

    qtd_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .push_in (push_src),
      .pop_in  (pop_src),
      .value   (cell_q[i])
    );
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd0;
      image_height <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        qtd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        qtd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      active <= 1'b0;
    end else if (accept && !is_space) begin
      if (is_split) begin
        if (overflow) begin
          count  <= '0;
          active <= 1'b0;
        end else begin
          count  <= count_plus3[CW-1:0];
          active <= 1'b1;
        end
      end else if (have_pending) begin
        count  <= eff_count - CW'(1);
        active <= 1'b1;
      end else begin
        count  <= '0;
        active <= 1'b0;
      end
    end
  end

  // The current region carries no reset; it is ignored while no tree is active.
  always_ff @(posedge clk) begin
    if (accept && !is_space) begin
      if (is_split) begin
        cur <= nw_child;
      end else if (have_pending) begin
        cur <= cell_q[0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && !is_space && (!is_split || overflow)) begin
      out_valid <= 1'b1;
    end else if (rect_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_space) begin
      if (is_split) begin
        out_rect <= '0;
        out_fill <= 16'd0;
        out_done <= 1'b0;
        out_ovf  <= 1'b1;
      end else begin
        out_rect <= eff_cur;
        out_fill <= {8'd0, sym_chan.symbol} - {8'd0, qtd_pkg::SYM_ZERO};
        out_done <= !have_pending;
        out_ovf  <= 1'b0;
      end
    end
  end

  assign rect_chan.valid          = out_valid;
  assign rect_chan.rect_x0        = out_rect.x0;
  assign rect_chan.rect_y0        = out_rect.y0;
  assign rect_chan.rect_x1        = out_rect.x1;
  assign rect_chan.rect_y1        = out_rect.y1;
  assign rect_chan.fill_value     = out_fill;
  assign rect_chan.tree_done      = out_done;
  assign rect_chan.overflow_error = out_ovf;

  // The stack never holds more regions than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("pending count beyond stack depth");

  // Whitespace leaves the stack depth and the tree state untouched.
  a_space_idle: assert property (@(posedge clk) disable iff (rst)
    accept && is_space |=> $stable(count) && $stable(active))
    else $error("whitespace changed decoder state");

  // An overflow drops the tree and empties the stack.
  a_ovf_drop: assert property (@(posedge clk) disable iff (rst)
    accept && is_split && overflow |=> !active && (count == '0) && out_valid && out_ovf)
    else $error("overflow did not drop the tree");

  // An overflow result never also claims to finish the tree.
  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> !out_done)
    else $error("overflow result marked tree done");

  // Input is held off only while a result waits to be transferred.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sym_chan.ready |-> out_valid && !rect_chan.ready)
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

// ----- hdl/qtd_cell.sv -----
// ============================================================================
// Quadtree stack cell
// One entry of the pending-region stack; shifts by three on a push, by one
// on a pop, and holds otherwise.
// ============================================================================
`default_nettype none

module qtd_cell (
  input  wire logic               clk,
  input  wire qtd_pkg::cell_ctrl_t ctrl,
  input  wire qtd_pkg::region_t   push_in,
  input  wire qtd_pkg::region_t   pop_in,
  output qtd_pkg::region_t        value
);

  qtd_pkg::region_t entry;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= push_in;
    end else if (ctrl.pop) begin
      entry <= pop_in;
    end
  end

  assign value = entry;

endmodule

`default_nettype wire
